// ----- rtl/salfu_pkg.sv -----
package salfu_pkg;

	localparam int ADDR_W     = 32;
	localparam int SETS       = 64;
	localparam int WAYS       = 8;
	localparam int COUNT_BITS = 16;

	localparam int SET_BITS = $clog2(SETS);
	localparam int WAY_BITS = $clog2(WAYS);
	localparam int WAY_POW  = 1 << WAY_BITS;
	localparam int NW_W     = WAY_BITS + 1;
	localparam int KEY_W    = COUNT_BITS + 1;
	localparam int TAG_W    = ADDR_W;

	localparam int OFFSET_W = 4;
	localparam int INDEX_W  = 3;
	localparam int WAYSCFG_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam int OUT_WAY_W = 3;
	localparam int OUT_SET_W = 6;
	localparam int OUT_DATA_W = 16;

	localparam logic [OFFSET_W-1:0]  OFFSET_RST = OFFSET_W'(2);
	localparam logic [INDEX_W-1:0]   INDEX_RST  = INDEX_W'(6);
	localparam logic [WAYSCFG_W-1:0] WAYS_RST   = WAYSCFG_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] cnt;
		logic [TAG_W-1:0]      tag;
		logic                  vld;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

// ----- rtl/salfu_ram.sv -----
module salfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/set_assoc_cache_lfu_lookup_top.sv -----
// Flow: a taken address is registered, its set row in the tag/count memory is read
// and keyed in the read state, and the evaluate state writes the row back and registers
// the result once the output can advance. The next address is not taken until then.
// Reset: registers return to offset 2, index 6, ways 8; per-set row flags
// clear so every set reads empty at once, with no clearing pass.
module set_assoc_cache_lfu_lookup_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [salfu_pkg::ADDR_W-1:0]          s_tdata,   // address[31:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [salfu_pkg::OUT_DATA_W-1:0]      m_tdata,   // way[2:0], set_index[8:3],
	                                                         // replaced_valid[9], zero
	output logic                                  m_tuser,   // hit[0]
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [salfu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [salfu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	salfu_pkg::state_t state_q, state_d;

	logic [salfu_pkg::OFFSET_W-1:0]  offset_bits_q;
	logic [salfu_pkg::INDEX_W-1:0]   index_bits_q;
	logic [salfu_pkg::WAYSCFG_W-1:0] ways_in_use_q;

	logic [salfu_pkg::SETS-1:0] rowv_q;

	logic [salfu_pkg::SET_BITS-1:0] set_s1;
	logic [salfu_pkg::TAG_W-1:0]    tag_s1;
	logic [salfu_pkg::NW_W-1:0]     nw_s1;
	logic                           rowv_s1;
	logic                           fwd_s1;

	salfu_pkg::row_t                row_s2;
	logic [salfu_pkg::WAYS-1:0]     hitv_s2;
	logic [salfu_pkg::KEY_W-1:0]    key_s2 [salfu_pkg::WAYS];

	salfu_pkg::row_t wrow_q;

	logic                               out_valid_q;
	logic                               out_hit_q;
	logic [salfu_pkg::OUT_WAY_W-1:0]    out_way_q;
	logic [salfu_pkg::OUT_SET_W-1:0]    out_set_q;
	logic                               out_repl_q;

	logic                           accept;
	logic                           advance;
	logic [salfu_pkg::ADDR_W-1:0]   set_wide;
	logic [salfu_pkg::SET_BITS-1:0] set_new;
	logic [4:0]                     tag_shift;
	logic [salfu_pkg::TAG_W-1:0]    tag_new;
	logic [salfu_pkg::NW_W-1:0]     nw_new;

	logic [salfu_pkg::ROW_W-1:0]    ram_rdata;
	salfu_pkg::row_t                row_rd;
	salfu_pkg::row_t                row_new;

	logic [salfu_pkg::KEY_W-1:0]    tk [salfu_pkg::WAY_BITS+1][salfu_pkg::WAY_POW];
	logic [salfu_pkg::WAY_BITS-1:0] ti [salfu_pkg::WAY_BITS+1][salfu_pkg::WAY_POW];

	logic                           hit;
	logic [salfu_pkg::WAY_BITS-1:0] hit_way;
	logic [salfu_pkg::WAY_BITS-1:0] victim;
	logic [salfu_pkg::WAY_BITS-1:0] res_way;
	logic                           evicted;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= salfu_pkg::OFFSET_RST;
			index_bits_q  <= salfu_pkg::INDEX_RST;
			ways_in_use_q <= salfu_pkg::WAYS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				salfu_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data[salfu_pkg::OFFSET_W-1:0];
				salfu_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data[salfu_pkg::INDEX_W-1:0];
				salfu_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[salfu_pkg::WAYSCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// address split
	always_comb begin
		set_wide  = (s_tdata >> offset_bits_q) &
		            ~({salfu_pkg::ADDR_W{1'b1}} << index_bits_q);
		set_new   = set_wide[salfu_pkg::SET_BITS-1:0];
		tag_shift = {1'b0, offset_bits_q} + {2'b00, index_bits_q};
		tag_new   = s_tdata >> tag_shift;
		if (ways_in_use_q == '0) begin
			nw_new = salfu_pkg::NW_W'(1);
		end else if (32'(ways_in_use_q) > salfu_pkg::WAYS) begin
			nw_new = salfu_pkg::NW_W'(salfu_pkg::WAYS);
		end else begin
			nw_new = salfu_pkg::NW_W'(ways_in_use_q);
		end
	end

	assign advance = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			salfu_pkg::ST_IDLE: if (s_tvalid) state_d = salfu_pkg::ST_READ;
			salfu_pkg::ST_READ: state_d = salfu_pkg::ST_EVAL;
			salfu_pkg::ST_EVAL: begin
				if (advance) begin
					state_d = s_tvalid ? salfu_pkg::ST_READ : salfu_pkg::ST_IDLE;
				end
			end
			default: state_d = salfu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			salfu_pkg::ST_IDLE: s_tready = 1'b1;
			salfu_pkg::ST_EVAL: s_tready = advance;
			default:            s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1  <= set_new;
			tag_s1  <= tag_new;
			nw_s1   <= nw_new;
			rowv_s1 <= rowv_q[set_new];
			fwd_s1  <= (state_q == salfu_pkg::ST_EVAL) && (set_new == set_s1);
		end
	end

	salfu_ram #(
		.WIDTH (salfu_pkg::ROW_W),
		.DEPTH (salfu_pkg::SETS)
	) u_ram (
		.clk   (clk),
		.we    ((state_q == salfu_pkg::ST_EVAL) && advance),
		.waddr (set_s1),
		.wdata (row_new),
		.re    (accept),
		.raddr (set_new),
		.rdata (ram_rdata)
	);

	// match and replacement keys
	always_comb begin
		if (fwd_s1) begin
			row_rd = wrow_q;
		end else if (rowv_s1) begin
			row_rd = salfu_pkg::row_t'(ram_rdata);
		end else begin
			row_rd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == salfu_pkg::ST_READ) begin
			row_s2 <= row_rd;
			for (int w = 0; w < salfu_pkg::WAYS; w++) begin
				hitv_s2[w] <= (salfu_pkg::NW_W'(w) < nw_s1) && row_rd[w].vld &&
				              (row_rd[w].tag == tag_s1);
				if (salfu_pkg::NW_W'(w) >= nw_s1) begin
					key_s2[w] <= '1;
				end else if (row_rd[w].vld) begin
					key_s2[w] <= {1'b0, row_rd[w].cnt};
				end else begin
					key_s2[w] <= '0;
				end
			end
		end
	end

	// minimum tree, lower way wins ties
	always_comb begin
		for (int l = 0; l <= salfu_pkg::WAY_BITS; l++) begin
			for (int i = 0; i < salfu_pkg::WAY_POW; i++) begin
				tk[l][i] = '1;
				ti[l][i] = '0;
			end
		end
		for (int i = 0; i < salfu_pkg::WAYS; i++) begin
			tk[0][i] = key_s2[i];
			ti[0][i] = salfu_pkg::WAY_BITS'(i);
		end
		for (int l = 1; l <= salfu_pkg::WAY_BITS; l++) begin
			for (int i = 0; i < (salfu_pkg::WAY_POW >> l); i++) begin
				if (tk[l-1][2*i+1] < tk[l-1][2*i]) begin
					tk[l][i] = tk[l-1][2*i+1];
					ti[l][i] = ti[l-1][2*i+1];
				end else begin
					tk[l][i] = tk[l-1][2*i];
					ti[l][i] = ti[l-1][2*i];
				end
			end
		end
		victim = ti[salfu_pkg::WAY_BITS][0];
	end

	always_comb begin
		hit     = |hitv_s2;
		hit_way = '0;
		for (int w = salfu_pkg::WAYS - 1; w >= 0; w--) begin
			if (hitv_s2[w]) begin
				hit_way = salfu_pkg::WAY_BITS'(w);
			end
		end
		row_new = row_s2;
		if (hit) begin
			if (row_s2[hit_way].cnt != '1) begin
				row_new[hit_way].cnt = row_s2[hit_way].cnt + 1'b1;
			end
			res_way = hit_way;
			evicted = 1'b0;
		end else begin
			row_new[victim].vld = 1'b1;
			row_new[victim].tag = tag_s1;
			row_new[victim].cnt = salfu_pkg::COUNT_BITS'(1);
			res_way = victim;
			evicted = row_s2[victim].vld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q      <= '0;
			out_valid_q <= 1'b0;
		end else if ((state_q == salfu_pkg::ST_EVAL) && advance) begin
			rowv_q[set_s1] <= 1'b1;
			out_valid_q    <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == salfu_pkg::ST_EVAL) && advance) begin
			wrow_q     <= row_new;
			out_hit_q  <= hit;
			out_way_q  <= salfu_pkg::OUT_WAY_W'(res_way);
			out_set_q  <= salfu_pkg::OUT_SET_W'(set_s1);
			out_repl_q <= evicted;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = salfu_pkg::OUT_DATA_W'({out_repl_q, out_set_q, out_way_q});

endmodule
